// ===== hdl/bresenham_line_rasterizer_macros.svh =====
// Assertion macros for the line rasterizer.
`ifndef BRESENHAM_LINE_RASTERIZER_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition on this edge implies a condition on the same edge.
`define BLR_ASSERT_SAME(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("assertion failed: same-cycle implication");

// Condition on this edge implies a condition on the next edge.
`define BLR_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("assertion failed: next-cycle implication");

`else

`define BLR_ASSERT_SAME(label, clk, rst_n, cond, conseq)
`define BLR_ASSERT_NEXT(label, clk, rst_n, cond, conseq)

`endif

`endif

// ===== hdl/blr_pkg.sv =====
// Types and constants shared by the line rasterizer.
`default_nettype none

package blr_pkg;

    localparam int COORD_BITS   = 12;
    localparam int CHANNEL_BITS = 8;
    localparam int VIEW_BITS    = 12;
    localparam int CFG_IDX_BITS = 2;

    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int CMP_BITS   = (COORD_BITS > VIEW_BITS) ? COORD_BITS : VIEW_BITS;

    typedef enum logic {
        ACT_START   = 1'b0,
        ACT_ADVANCE = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_VIEW_WIDTH  = 2'd0,
        CFG_VIEW_HEIGHT = 2'd1
    } t_cfg_index;

    localparam logic [VIEW_BITS-1:0] VIEW_WIDTH_RESET  = VIEW_BITS'(1280);
    localparam logic [VIEW_BITS-1:0] VIEW_HEIGHT_RESET = VIEW_BITS'(720);

    typedef struct packed {
        t_action                       action;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
        logic [CHANNEL_BITS-1:0]       red_in;
        logic [CHANNEL_BITS-1:0]       green_in;
        logic [CHANNEL_BITS-1:0]       blue_in;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic [CHANNEL_BITS-1:0]       red_out;
        logic [CHANNEL_BITS-1:0]       green_out;
        logic [CHANNEL_BITS-1:0]       blue_out;
        logic                          inside_view;
        logic                          last_pixel;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hdl/bresenham_line_rasterizer.sv =====
// Bresenham line rasterizer: all octants, both endpoints inclusive.
// A start request loads the endpoints and color and emits nothing; each
// advance request on a live line emits the next pixel of the line, flagged
// inside-viewport and last-pixel. One request is taken per clock: the line state (cursor,
// error term, deltas) updates with one add and compare per axis in the
// cycle the request is accepted, and the pixel lands in an output register.
// A request is taken whenever that register is empty or being drained, so
// a line streams at one pixel per clock while the output is not stalled.
`default_nettype none
`include "bresenham_line_rasterizer_macros.svh"

module bresenham_line_rasterizer (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  blr_pkg::t_in_item                    i_in_data,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output blr_pkg::t_out_item                   o_out_data,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [blr_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire  [blr_pkg::VIEW_BITS-1:0]        i_cfg_data
);

    localparam int C  = blr_pkg::COORD_BITS;
    localparam int CH = blr_pkg::CHANNEL_BITS;
    localparam int D  = blr_pkg::DELTA_BITS;
    localparam int E  = blr_pkg::ERR_BITS;
    localparam int E2 = blr_pkg::ERR_BITS + 1;
    localparam int CB = blr_pkg::CMP_BITS;

    logic [blr_pkg::VIEW_BITS-1:0] r_view_w, r_view_h;

    logic signed [C-1:0] r_cursor_x, r_cursor_y, r_target_x, r_target_y;
    logic [D-1:0]        r_abs_dx, r_abs_dy;
    logic signed [E-1:0] r_err;
    logic                r_neg_x, r_neg_y;
    logic [CH-1:0]       r_red, r_green, r_blue;
    logic                r_active;

    logic                r_out_valid;
    blr_pkg::t_out_item  r_out_data;

    logic signed [C-1:0] n_cursor_x, n_cursor_y;
    logic [D-1:0]        n_abs_dx, n_abs_dy;
    logic signed [E-1:0] n_err;
    logic                n_neg_x, n_neg_y;
    logic                n_active;
    logic                n_out_valid;
    blr_pkg::t_out_item  n_out_data;

    logic                w_in_acc, w_out_acc, w_cfg_acc;
    logic                w_is_start;
    logic                w_last, w_inside, w_step_x, w_step_y;
    logic signed [E2-1:0] w_e2, w_dx_e2, w_dy_e2;
    logic signed [D-1:0] w_diff_x, w_diff_y;
    logic signed [C-1:0] w_inc_x, w_inc_y;
    logic signed [E-1:0] w_err_sub, w_err_add;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = r_out_valid && i_out_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_is_start  = (i_in_data.action == blr_pkg::ACT_START);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Current pixel and its stepping decision.
    always_comb begin
        w_last   = (r_cursor_x == r_target_x) && (r_cursor_y == r_target_y);
        w_inside = !r_cursor_x[C-1] && !r_cursor_y[C-1]
                && (CB'($unsigned(r_cursor_x)) < CB'(r_view_w))
                && (CB'($unsigned(r_cursor_y)) < CB'(r_view_h));
        w_e2     = {r_err, 1'b0};
        w_dx_e2  = $signed(E2'(r_abs_dx));
        w_dy_e2  = $signed(E2'(r_abs_dy));
        w_step_x = (w_e2 >= -w_dy_e2);
        w_step_y = (w_e2 <= w_dx_e2);
        w_inc_x  = !w_step_x ? '0 : (r_neg_x ? '1 : C'(1));
        w_inc_y  = !w_step_y ? '0 : (r_neg_y ? '1 : C'(1));
        w_err_sub = w_step_x ? $signed(E'(r_abs_dy)) : '0;
        w_err_add = w_step_y ? $signed(E'(r_abs_dx)) : '0;

        w_diff_x = D'(i_in_data.end_x) - D'(i_in_data.start_x);
        w_diff_y = D'(i_in_data.end_y) - D'(i_in_data.start_y);
    end

    // Next line state and output register.
    always_comb begin
        n_cursor_x  = r_cursor_x;
        n_cursor_y  = r_cursor_y;
        n_abs_dx    = r_abs_dx;
        n_abs_dy    = r_abs_dy;
        n_err       = r_err;
        n_neg_x     = r_neg_x;
        n_neg_y     = r_neg_y;
        n_active    = r_active;
        n_out_valid = r_out_valid && !w_out_acc;
        n_out_data  = r_out_data;

        n_out_data.pixel_x     = r_cursor_x;
        n_out_data.pixel_y     = r_cursor_y;
        n_out_data.red_out     = r_red;
        n_out_data.green_out   = r_green;
        n_out_data.blue_out    = r_blue;
        n_out_data.inside_view = w_inside;
        n_out_data.last_pixel  = w_last;
        // keep the held result when nothing new is produced
        if (!(w_in_acc && !w_is_start && r_active)) begin
            n_out_data = r_out_data;
        end

        if (w_in_acc) begin
            if (w_is_start) begin
                n_cursor_x = i_in_data.start_x;
                n_cursor_y = i_in_data.start_y;
                n_neg_x    = w_diff_x[D-1];
                n_neg_y    = w_diff_y[D-1];
                n_abs_dx   = w_diff_x[D-1] ? D'(-w_diff_x) : D'(w_diff_x);
                n_abs_dy   = w_diff_y[D-1] ? D'(-w_diff_y) : D'(w_diff_y);
                n_err      = $signed(E'(n_abs_dx)) - $signed(E'(n_abs_dy));
                n_active   = 1'b1;
            end else if (r_active) begin
                n_out_valid = 1'b1;
                if (w_last) begin
                    n_active = 1'b0;
                end else begin
                    n_cursor_x = r_cursor_x + w_inc_x;
                    n_cursor_y = r_cursor_y + w_inc_y;
                    n_err      = r_err - w_err_sub + w_err_add;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cursor_x <= n_cursor_x;
        r_cursor_y <= n_cursor_y;
        r_abs_dx   <= n_abs_dx;
        r_abs_dy   <= n_abs_dy;
        r_err      <= n_err;
        r_neg_x    <= n_neg_x;
        r_neg_y    <= n_neg_y;
        r_out_data <= n_out_data;
        if (w_in_acc && w_is_start) begin
            r_target_x <= i_in_data.end_x;
            r_target_y <= i_in_data.end_y;
            r_red      <= i_in_data.red_in;
            r_green    <= i_in_data.green_in;
            r_blue     <= i_in_data.blue_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_view_w    <= blr_pkg::VIEW_WIDTH_RESET;
            r_view_h    <= blr_pkg::VIEW_HEIGHT_RESET;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    blr_pkg::CFG_VIEW_WIDTH:  r_view_w <= i_cfg_data;
                    blr_pkg::CFG_VIEW_HEIGHT: r_view_h <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // A start request never produces a pixel and always arms the line.
    `BLR_ASSERT_NEXT(a_start_arms, i_clk, i_rst_n, w_in_acc && w_is_start, r_active && !r_out_valid)
    // Advancing with no line leaves the output empty.
    `BLR_ASSERT_NEXT(a_idle_advance, i_clk, i_rst_n, w_in_acc && !w_is_start && !r_active, !r_out_valid)
    // Advancing on a live line always yields a pixel.
    `BLR_ASSERT_NEXT(a_live_advance, i_clk, i_rst_n, w_in_acc && !w_is_start && r_active, r_out_valid)
    // The final pixel retires the line unless a new one was started.
    `BLR_ASSERT_SAME(a_last_retires, i_clk, i_rst_n, $rose(r_out_valid) && r_out_data.last_pixel && !$past(w_in_acc && w_is_start), !r_active)

endmodule

`default_nettype wire

// ===== dv/bresenham_line_rasterizer_tb.sv =====
// Self-checking testbench for the line rasterizer: directed rows, random lines, viewport sweeps.
`timescale 1ns / 100ps

module bresenham_line_rasterizer_tb;

    localparam int COORD_BITS   = blr_pkg::COORD_BITS;
    localparam int CHANNEL_BITS = blr_pkg::CHANNEL_BITS;
    localparam int VIEW_BITS    = blr_pkg::VIEW_BITS;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 6;
    localparam int PHASE_WORK    = 215;
    localparam int PROBE_ROWS    = 27;

    typedef enum {ROW_PRED, ROW_NONE, ROW_PIXEL} t_row_kind;

    // Start rows carry the line color; pixel rows carry the color they expect.
    typedef struct {
        t_row_kind        kind;
        blr_pkg::t_action act;
        int               sx, sy, ex, ey;
        int               rgb;
        int               px, py;
        bit               pin, plast;
    } t_probe_row;

    t_probe_row probe_rows [PROBE_ROWS] = '{
        '{ROW_NONE,  blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'h000000, 0, 0, 0, 0},
        '{ROW_NONE,  blr_pkg::ACT_START,   0, 0, 0, 0, 'hff0080, 0, 0, 0, 0},
        '{ROW_PIXEL, blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'hff0080, 0, 0, 1, 1},
        '{ROW_NONE,  blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'hff0080, 0, 0, 0, 0},
        '{ROW_NONE,  blr_pkg::ACT_START,   -2048, -2048, -2048, -2048, 'h000000, 0, 0, 0, 0},
        '{ROW_PIXEL, blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'h000000, -2048, -2048, 0, 1},
        '{ROW_NONE,  blr_pkg::ACT_START,   2047, 2047, 2047, 2047, 'hffffff, 0, 0, 0, 0},
        '{ROW_PIXEL, blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'hffffff, 2047, 2047, 0, 1},
        '{ROW_NONE,  blr_pkg::ACT_START,   1279, 719, 1280, 720, 'h123456, 0, 0, 0, 0},
        '{ROW_PIXEL, blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'h123456, 1279, 719, 1, 0},
        '{ROW_PIXEL, blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'h123456, 1280, 720, 0, 1},
        '{ROW_NONE,  blr_pkg::ACT_START,   0, 0, 3, 1, 'h00ff00, 0, 0, 0, 0},
        '{ROW_PRED,  blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'h00ff00, 0, 0, 0, 0},
        '{ROW_PRED,  blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'h00ff00, 0, 0, 0, 0},
        '{ROW_PRED,  blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'h00ff00, 0, 0, 0, 0},
        '{ROW_PRED,  blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'h00ff00, 0, 0, 0, 0},
        '{ROW_NONE,  blr_pkg::ACT_START,   5, 0, 5, 3, 'h0000ff, 0, 0, 0, 0},
        '{ROW_PRED,  blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'h0000ff, 0, 0, 0, 0},
        '{ROW_PRED,  blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'h0000ff, 0, 0, 0, 0},
        '{ROW_PRED,  blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'h0000ff, 0, 0, 0, 0},
        '{ROW_PRED,  blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'h0000ff, 0, 0, 0, 0},
        '{ROW_NONE,  blr_pkg::ACT_START,   2, 5, 0, -1, 'ha5a5a5, 0, 0, 0, 0},
        '{ROW_PRED,  blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'ha5a5a5, 0, 0, 0, 0},
        '{ROW_PRED,  blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'ha5a5a5, 0, 0, 0, 0},
        '{ROW_NONE,  blr_pkg::ACT_START,   -2048, 2047, 2047, -2048, 'h5a5a5a, 0, 0, 0, 0},
        '{ROW_PRED,  blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'h5a5a5a, 0, 0, 0, 0},
        '{ROW_PRED,  blr_pkg::ACT_ADVANCE, 0, 0, 0, 0, 'h5a5a5a, 0, 0, 0, 0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    blr_pkg::t_in_item in_data = '0;
    logic out_ready = 1'b0;
    logic cfg_valid = 1'b0;
    blr_pkg::t_cfg_index cfg_index = blr_pkg::CFG_VIEW_WIDTH;
    logic [VIEW_BITS-1:0] cfg_data = '0;
    wire in_ready;
    wire out_valid;
    wire cfg_ready;
    blr_pkg::t_out_item out_data;

    bresenham_line_rasterizer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Line state of the predictor.
    int view_w = blr_pkg::VIEW_WIDTH_RESET;
    int view_h = blr_pkg::VIEW_HEIGHT_RESET;
    int cur_x, cur_y, tgt_x, tgt_y, span_x, span_y, err_acc;
    bit dir_x_neg, dir_y_neg, line_live;
    logic [CHANNEL_BITS-1:0] col_r, col_g, col_b;

    blr_pkg::t_out_item owed_pixels[$];
    int mismatches;
    int lines_started;
    int work_done;
    int pixels_seen;
    int inside_seen;
    int quiet_cycles;
    int stall_left;
    bit sink_steady;
    bit feed_steady;

    function automatic bit rasterize(input blr_pkg::t_in_item req,
                                     output blr_pkg::t_out_item px);
        int e2;
        px = '0;
        if (req.action == blr_pkg::ACT_START) begin
            cur_x = int'(req.start_x);
            cur_y = int'(req.start_y);
            tgt_x = int'(req.end_x);
            tgt_y = int'(req.end_y);
            dir_x_neg = tgt_x < cur_x;
            dir_y_neg = tgt_y < cur_y;
            span_x = dir_x_neg ? cur_x - tgt_x : tgt_x - cur_x;
            span_y = dir_y_neg ? cur_y - tgt_y : tgt_y - cur_y;
            err_acc = span_x - span_y;
            col_r = req.red_in;
            col_g = req.green_in;
            col_b = req.blue_in;
            line_live = 1'b1;
            return 1'b0;
        end
        if (!line_live)
            return 1'b0;
        px.pixel_x = COORD_BITS'(cur_x);
        px.pixel_y = COORD_BITS'(cur_y);
        px.red_out = col_r;
        px.green_out = col_g;
        px.blue_out = col_b;
        px.inside_view = cur_x >= 0 && cur_y >= 0 && cur_x < view_w && cur_y < view_h;
        px.last_pixel = cur_x == tgt_x && cur_y == tgt_y;
        if (px.last_pixel) begin
            line_live = 1'b0;
        end else begin
            e2 = 2 * err_acc;
            if (e2 >= -span_y) begin
                err_acc -= span_y;
                cur_x += dir_x_neg ? -1 : 1;
            end
            if (e2 <= span_x) begin
                err_acc += span_x;
                cur_y += dir_y_neg ? -1 : 1;
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int clamp_coord(int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    // Bias origins toward the viewport and its edges, with some full-range and extreme picks.
    function automatic int pick_origin(int view);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return clamp_coord(int'($urandom_range(0, view + 4)) - 2);
        if (r < 7)
            return clamp_coord(view - 2 + int'($urandom_range(0, 4)));
        if (r < 8)
            return $urandom_range(0, 1) ? -2048 : 2047;
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    always @(posedge clk) begin : pixel_sink
        blr_pkg::t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            pixels_seen++;
            if (out_data.inside_view)
                inside_seen++;
            if (owed_pixels.size() == 0) begin
                report_mismatch("pixel with none owed, x", int'(out_data.pixel_x), 0);
            end else begin
                want = owed_pixels.pop_front();
                if (out_data.pixel_x !== want.pixel_x)
                    report_mismatch("pixel_x", int'(out_data.pixel_x), int'(want.pixel_x));
                if (out_data.pixel_y !== want.pixel_y)
                    report_mismatch("pixel_y", int'(out_data.pixel_y), int'(want.pixel_y));
                if (out_data.red_out !== want.red_out)
                    report_mismatch("red_out", int'(out_data.red_out), int'(want.red_out));
                if (out_data.green_out !== want.green_out)
                    report_mismatch("green_out", int'(out_data.green_out), int'(want.green_out));
                if (out_data.blue_out !== want.blue_out)
                    report_mismatch("blue_out", int'(out_data.blue_out), int'(want.blue_out));
                if (out_data.inside_view !== want.inside_view)
                    report_mismatch("inside_view", int'(out_data.inside_view),
                                    int'(want.inside_view));
                if (out_data.last_pixel !== want.last_pixel)
                    report_mismatch("last_pixel", int'(out_data.last_pixel),
                                    int'(want.last_pixel));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!sink_steady && $urandom_range(0, 9) < 2) begin
            stall_left = pick_pause() - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(blr_pkg::t_in_item req);
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic sender_pause();
        if (!feed_steady && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat (pick_pause()) @(posedge clk);
        end
    endtask

    task automatic issue(blr_pkg::t_in_item req);
        blr_pkg::t_out_item px;
        send_request(req);
        if (req.action == blr_pkg::ACT_START)
            lines_started++;
        if (rasterize(req, px)) begin
            owed_pixels.push_back(px);
            work_done++;
        end else if (req.action == blr_pkg::ACT_START) begin
            work_done++;
        end
        sender_pause();
    endtask

    // Hold off until every owed pixel is back and the pipeline has gone quiet.
    task automatic wait_drained();
        if (in_valid)
            in_valid <= 1'b0;
        while (owed_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_viewport(int w, int h);
        cfg_valid <= 1'b1;
        cfg_index <= blr_pkg::CFG_VIEW_WIDTH;
        cfg_data <= VIEW_BITS'(w);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        view_w = w & ((1 << VIEW_BITS) - 1);
        cfg_index <= blr_pkg::CFG_VIEW_HEIGHT;
        cfg_data <= VIEW_BITS'(h);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        view_h = h & ((1 << VIEW_BITS) - 1);
    endtask

    // A line start and its advances, some running over or cut short; or random requests alone.
    task automatic issue_line();
        int sx, sy, ex, ey, dx, dy, reach, steps, mode;
        logic [95:0] noise;
        blr_pkg::t_in_item req;
        mode = $urandom_range(0, 99);
        if (mode >= 94) begin
            repeat ($urandom_range(1, 4)) begin
                noise = {$urandom(), $urandom(), $urandom()};
                issue(noise[$bits(blr_pkg::t_in_item)-1:0]);
            end
            return;
        end
        sx = pick_origin(view_w);
        sy = pick_origin(view_h);
        if (mode < 10) begin
            ex = int'($urandom_range(0, 4095)) - 2048;
            ey = int'($urandom_range(0, 4095)) - 2048;
            steps = $urandom_range(0, 12);
        end else begin
            reach = ($urandom_range(0, 9) == 0) ? 60 : 8;
            ex = clamp_coord(sx + int'($urandom_range(0, 2 * reach)) - reach);
            ey = clamp_coord(sy + int'($urandom_range(0, 2 * reach)) - reach);
            dx = (ex > sx) ? ex - sx : sx - ex;
            dy = (ey > sy) ? ey - sy : sy - ey;
            steps = ((dx > dy) ? dx : dy) + 1;
            if (mode < 20)
                steps += $urandom_range(1, 3);
            else if (mode < 28)
                steps = $urandom_range(0, steps - 1);
        end
        noise = {$urandom(), $urandom(), $urandom()};
        req = noise[$bits(blr_pkg::t_in_item)-1:0];
        req.action = blr_pkg::ACT_START;
        req.start_x = COORD_BITS'(sx);
        req.start_y = COORD_BITS'(sy);
        req.end_x = COORD_BITS'(ex);
        req.end_y = COORD_BITS'(ey);
        issue(req);
        repeat (steps) begin
            noise = {$urandom(), $urandom(), $urandom()};
            req = noise[$bits(blr_pkg::t_in_item)-1:0];
            req.action = blr_pkg::ACT_ADVANCE;
            issue(req);
        end
        if ($urandom_range(0, 49) == 0)
            wait_drained();
    endtask

    initial begin
        int phase_w [PHASES] = '{4095, 1, 2048, 2047, 64, 0};
        int phase_h [PHASES] = '{4095, 1, 2047, 2048, 48, 0};
        int w, h, phase_goal;
        blr_pkg::t_in_item req;
        blr_pkg::t_out_item px, typed_px;
        bit got_one;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_rows[i]) begin
            req = '0;
            req.action = probe_rows[i].act;
            req.start_x = COORD_BITS'(probe_rows[i].sx);
            req.start_y = COORD_BITS'(probe_rows[i].sy);
            req.end_x = COORD_BITS'(probe_rows[i].ex);
            req.end_y = COORD_BITS'(probe_rows[i].ey);
            req.red_in = CHANNEL_BITS'(probe_rows[i].rgb >> (2 * CHANNEL_BITS));
            req.green_in = CHANNEL_BITS'(probe_rows[i].rgb >> CHANNEL_BITS);
            req.blue_in = CHANNEL_BITS'(probe_rows[i].rgb);
            send_request(req);
            got_one = rasterize(req, px);
            if (probe_rows[i].kind == ROW_PRED && got_one) begin
                owed_pixels.push_back(px);
            end else if (probe_rows[i].kind == ROW_PIXEL) begin
                typed_px.pixel_x = COORD_BITS'(probe_rows[i].px);
                typed_px.pixel_y = COORD_BITS'(probe_rows[i].py);
                typed_px.red_out = req.red_in;
                typed_px.green_out = req.green_in;
                typed_px.blue_out = req.blue_in;
                typed_px.inside_view = probe_rows[i].pin;
                typed_px.last_pixel = probe_rows[i].plast;
                owed_pixels.push_back(typed_px);
            end
            sender_pause();
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            w = (phase == PHASES - 1) ? int'($urandom_range(1, 4095)) : phase_w[phase];
            h = (phase == PHASES - 1) ? int'($urandom_range(1, 4095)) : phase_h[phase];
            set_viewport(w, h);
            sink_steady = (phase % 3 == 1);
            feed_steady = (phase % 3 == 2);
            phase_goal = work_done + PHASE_WORK;
            while (work_done < phase_goal)
                issue_line();
        end

        wait_drained();
        if (owed_pixels.size() != 0)
            report_mismatch("pixels still owed", owed_pixels.size(), 0);
        $display("Covered %0d line starts and %0d pixels, %0d of them inside the viewport,",
                 lines_started, pixels_seen, inside_seen);
        $display("over the reset viewport and %0d programmed viewport settings.", PHASES);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
